FILE: hdl/lfd_pkg.sv
package lfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned KIND_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [KIND_W-1:0] kind_t;

  // Result kinds
  localparam kind_t KIND_PAYLOAD  = 2'd0;
  localparam kind_t KIND_CRC_GOOD = 2'd1;
  localparam kind_t KIND_CRC_BAD  = 2'd2;
  localparam kind_t KIND_ABORT    = 2'd3;

  // Protocol constants
  localparam byte_t SYNC_BYTE       = 8'hAA;
  localparam byte_t ESC_ZERO        = 8'h00;
  localparam byte_t CRC_POLY        = 8'h07;
  localparam len_t  MAX_PAYLOAD_RST = 16'd252;

endpackage

FILE: hdl/lfd_if.sv
// Received byte channel
interface lfd_byte_if;
  import lfd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframer result channel
interface lfd_res_if;
  import lfd_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t payload_byte;
  logic  frame_last;
  modport source (output valid, output kind, output payload_byte, output frame_last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_last,
                  output ready);
endinterface

FILE: hdl/lfd_crc8.sv
// CRC-8 update over one byte, poly 0x07, MSB first, unrolled
module lfd_crc8 (
  input  lfd_pkg::byte_t crc_in,
  input  lfd_pkg::byte_t data_in,
  output lfd_pkg::byte_t crc_out
);
  import lfd_pkg::*;

  always_comb begin
    byte_t c;
    c = crc_in ^ data_in;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: hdl/length_framed_rx_deframer_crc8.sv
// Channel   | Dir | Payload                         | Handshake
// in_byte   | in  | rx_byte[7:0]                    | valid/ready
// out_res   | out | kind[1:0], payload_byte, last   | valid/ready
// cfg       | in  | cfg_wdata[15:0] (max_payload)   | cfg_we, no wait
//
// One item per cycle sustained while out_res is not stalled: a byte sits in the
// input register, the frame state, unescape and CRC-8 update are worked out
// combinationally into the result register. Reset (rst_n, synchronous) returns
// to hunting for sync and sets max_payload to 252.
// A stalled result holds the input register; ready then follows out_res.ready.
module length_framed_rx_deframer_crc8 (
  input  logic                clk,
  input  logic                rst_n,
  lfd_byte_if.sink            in_byte,
  lfd_res_if.source           out_res,
  input  logic                cfg_we,
  input  lfd_pkg::len_t       cfg_wdata
);
  import lfd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LENH = 2'd1,
    PH_LENL = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  phase_t phase_r, phase_nxt;
  len_t   max_len_r;
  len_t   exp_len_r, exp_len_nxt;
  len_t   taken_r, taken_nxt;
  logic   esc_r, esc_nxt;
  byte_t  crc_r, crc_nxt, crc_upd;

  logic   s1_v_r;
  byte_t  s1_byte_r;

  logic   out_v_r;
  kind_t  out_kind_r, res_kind;
  byte_t  out_byte_r, res_byte;
  logic   out_last_r, res_last;
  logic   res_v;

  byte_t  decoded;
  logic   proc;
  logic   in_fire;

  // Stage handshake: work proceeds when the result slot is free or draining
  assign proc            = s1_v_r && (!out_v_r || out_res.ready);
  assign in_byte.ready   = !s1_v_r || proc;
  assign in_fire         = in_byte.valid && in_byte.ready;

  assign out_res.valid        = out_v_r;
  assign out_res.kind         = out_kind_r;
  assign out_res.payload_byte = out_byte_r;
  assign out_res.frame_last   = out_last_r;

  // Unescape: escaped 0x00 stands for sync, other escaped bytes are literal
  assign decoded = (esc_r && (s1_byte_r == ESC_ZERO)) ? SYNC_BYTE : s1_byte_r;

  lfd_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (decoded),
    .crc_out (crc_upd)
  );

  // Frame state update for the byte in the input register
  always_comb begin
    phase_nxt   = phase_r;
    exp_len_nxt = exp_len_r;
    taken_nxt   = taken_r;
    esc_nxt     = esc_r;
    crc_nxt     = crc_r;
    res_v       = 1'b0;
    res_kind    = KIND_PAYLOAD;
    res_byte    = '0;
    res_last    = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (s1_byte_r == SYNC_BYTE) begin
          phase_nxt = PH_LENH;
          taken_nxt = '0;
          esc_nxt   = 1'b0;
          crc_nxt   = '0;
        end
      end
      PH_LENH: begin
        exp_len_nxt = {s1_byte_r, {BYTE_W{1'b0}}};
        phase_nxt   = PH_LENL;
      end
      PH_LENL: begin
        exp_len_nxt = {exp_len_r[LEN_W-1:BYTE_W], s1_byte_r};
        if ({exp_len_r[LEN_W-1:BYTE_W], s1_byte_r} > max_len_r) begin
          phase_nxt = PH_IDLE;
          res_v     = 1'b1;
          res_kind  = KIND_ABORT;
          res_last  = 1'b1;
        end else begin
          phase_nxt = PH_BODY;
          taken_nxt = '0;
          esc_nxt   = 1'b0;
          crc_nxt   = '0;
        end
      end
      PH_BODY: begin
        if (!esc_r && (s1_byte_r == SYNC_BYTE)) begin
          // escape mark, no item out
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          res_v   = 1'b1;
          if (taken_r < exp_len_r) begin
            crc_nxt   = crc_upd;
            taken_nxt = taken_r + 1'b1;
            res_kind  = KIND_PAYLOAD;
            res_byte  = decoded;
          end else begin
            phase_nxt = PH_IDLE;
            res_kind  = (crc_r == decoded) ? KIND_CRC_GOOD : KIND_CRC_BAD;
            res_last  = 1'b1;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Control state, frame state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      exp_len_r <= '0;
      taken_r   <= '0;
      esc_r     <= 1'b0;
      crc_r     <= '0;
      max_len_r <= MAX_PAYLOAD_RST;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (proc) begin
        s1_v_r <= 1'b0;
      end
      if (proc) begin
        phase_r   <= phase_nxt;
        exp_len_r <= exp_len_nxt;
        taken_r   <= taken_nxt;
        esc_r     <= esc_nxt;
        crc_r     <= crc_nxt;
        out_v_r   <= res_v;
      end else if (out_res.ready) begin
        out_v_r   <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte.rx_byte;
    end
    if (proc) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_last_r <= res_last;
    end
  end

endmodule

FILE: hdl/lfd_checker.sv
// Port-level checks on the deframer
module lfd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input lfd_pkg::kind_t out_kind,
  input lfd_pkg::byte_t out_payload_byte,
  input logic           out_frame_last
);
  import lfd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped or changed while stalled");

  // Frame end marker matches the kind
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_last == (out_kind != KIND_PAYLOAD)))
    else $error("frame_last disagrees with kind");

  // Only payload items carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PAYLOAD) |-> (out_payload_byte == '0))
    else $error("nonzero byte on frame end item");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind length_framed_rx_deframer_crc8 lfd_checker u_lfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_kind         (out_res.kind),
  .out_payload_byte (out_res.payload_byte),
  .out_frame_last   (out_res.frame_last)
);
